FILE: hdl/binary_border_extract_macros.svh
// Assertion macros used by the border extractor module.
`ifndef BINARY_BORDER_EXTRACT_MACROS_SVH
`define BINARY_BORDER_EXTRACT_MACROS_SVH
`ifndef SYNTHESIS
`define BBE_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("border extractor check failed");
`define BBE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("border extractor check failed");
`define BBE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("border extractor check failed");
`else
`define BBE_ASSERT(lbl, expr)
`define BBE_ASSERT_IMP(lbl, ante, cons)
`define BBE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hdl/bbe_pkg.sv
// Types and constants of the binary border extractor.
package bbe_pkg;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 11;
  localparam int ROW_W      = 10;
  localparam int COL_W      = 10;
  localparam int CELL_BITS  = 3;

  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  typedef struct packed {
    logic clr;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic             border;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             run_last;
  } result_t;

endpackage

FILE: hdl/bbe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bbe_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/bbe_cell.sv
// One window column cell: holds a three-pixel column, passes it on at each item and clears on clr.
module bbe_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bbe_pkg::cell_ctrl_t           ctrl,
  input  logic [bbe_pkg::CELL_BITS-1:0] d,
  output logic [bbe_pkg::CELL_BITS-1:0] q
);

  logic [bbe_pkg::CELL_BITS-1:0] col_r;
  logic [bbe_pkg::CELL_BITS-1:0] col_nxt;

  always_comb begin
    col_nxt = col_r;
    if (ctrl.clr) begin
      col_nxt = '0;
    end else if (ctrl.shift) begin
      col_nxt = d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else begin
      col_r <= col_nxt;
    end
  end

  assign q = col_r;

endmodule

FILE: hdl/binary_border_extract.sv
// Streaming 3x3 inner-border extractor for binary images in raster order.
// The block takes one pixel per clock cycle, sustained, with no stall while the result side
// keeps taking items. Each pixel reads the two stored rows above it from one two-bit-wide line
// RAM whose read address is the next column, and shifts a new column into a chain of two
// window cells. Results are registered into a two-entry queue and leave it one per cycle
// while out_ready is high; the last column of a row after row 0 gives two results, which
// the queue absorbs because the first column of the next row gives none. No clearing pass runs
// after reset: line RAM contents are only used once written. Any write to frame_width or
// frame_height restarts the frame at row 0, column 0; write them only while the block is idle.
`include "binary_border_extract_macros.svh"
module binary_border_extract #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_pixel,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_border,
  output logic [bbe_pkg::ROW_W-1:0]       out_row,
  output logic [bbe_pkg::COL_W-1:0]       out_col,
  output logic                            out_run_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bbe_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [bbe_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int WCMP_W = ($clog2(MAX_WIDTH + 1) > bbe_pkg::CFG_DATA_W) ?
                          $clog2(MAX_WIDTH + 1) : bbe_pkg::CFG_DATA_W;
  localparam int HCMP_W = ($clog2(MAX_HEIGHT + 1) > bbe_pkg::CFG_DATA_W) ?
                          $clog2(MAX_HEIGHT + 1) : bbe_pkg::CFG_DATA_W;
  localparam int RST_W  = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
  localparam int RST_H  = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] wlast_r, wlast_nxt;
  logic [RW-1:0] hlast_r, hlast_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  bbe_pkg::result_t q0_r, q0_nxt, q1_r, q1_nxt;

  logic              cfg_fire, wl_we, hl_we, frame_clr;
  logic [WCMP_W-1:0] wv, weff;
  logic [HCMP_W-1:0] hv, heff;

  logic in_fire, pop, last_col;
  logic [1:0] n_res, cnt_pop;
  logic [2:0] cnt_need;

  logic [1:0] line_q;
  logic [bbe_pkg::CELL_BITS-1:0] new_col, cell0_q, cell1_q;
  logic [8:0] window;
  logic       border_b;
  bbe_pkg::cell_ctrl_t cell_ctrl;
  bbe_pkg::result_t    res0, res1;

  // Configuration decode; dimensions are clamped once, at the write.
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;

  always_comb begin
    wl_we = 1'b0;
    hl_we = 1'b0;
    if (cfg_fire) begin
      unique case (cfg_addr)
        bbe_pkg::REG_FRAME_WIDTH:  wl_we = 1'b1;
        bbe_pkg::REG_FRAME_HEIGHT: hl_we = 1'b1;
        default: ;
      endcase
    end
  end

  assign frame_clr = wl_we | hl_we;

  always_comb begin
    wv = WCMP_W'(cfg_wdata);
    if (wv < WCMP_W'(3)) begin
      weff = WCMP_W'(3);
    end else if (wv > WCMP_W'(MAX_WIDTH)) begin
      weff = WCMP_W'(MAX_WIDTH);
    end else begin
      weff = wv;
    end
    hv = HCMP_W'(cfg_wdata);
    if (hv < HCMP_W'(3)) begin
      heff = HCMP_W'(3);
    end else if (hv > HCMP_W'(MAX_HEIGHT)) begin
      heff = HCMP_W'(MAX_HEIGHT);
    end else begin
      heff = hv;
    end
    wlast_nxt = wl_we ? CW'(weff - WCMP_W'(1)) : wlast_r;
    hlast_nxt = hl_we ? RW'(heff - HCMP_W'(1)) : hlast_r;
  end

  // Result count depends only on position, so ready is known before the pixel is seen.
  assign last_col = (col_r == wlast_r);

  always_comb begin
    n_res = 2'd0;
    if (row_r != '0) begin
      n_res = 2'((col_r != '0) ? 1 : 0) + 2'(last_col ? 1 : 0);
    end
  end

  assign pop      = out_valid & out_ready;
  assign cnt_pop  = cnt_r - {1'b0, pop};
  assign cnt_need = {1'b0, cnt_pop} + {1'b0, n_res};
  assign in_ready = (cnt_need <= 3'd2);
  assign in_fire  = in_valid & in_ready;

  always_comb begin
    if (!rst_n || frame_clr) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_fire) begin
      col_nxt = last_col ? '0 : col_r + CW'(1);
      if (last_col) begin
        row_nxt = (row_r == hlast_r) ? '0 : row_r + RW'(1);
      end else begin
        row_nxt = row_r;
      end
    end else begin
      col_nxt = col_r;
      row_nxt = row_r;
    end
  end

  // Entry holds {row above, two rows above}; the read address runs one item ahead.
  bbe_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (in_fire),
    .waddr (col_r),
    .wdata ({in_pixel, line_q[1]}),
    .raddr (col_nxt),
    .rdata (line_q)
  );

  assign new_col         = {line_q[0], line_q[1], in_pixel};
  assign cell_ctrl.clr   = frame_clr;
  assign cell_ctrl.shift = in_fire;

  bbe_cell u_cell0 (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (cell_ctrl),
    .d     (new_col),
    .q     (cell0_q)
  );

  bbe_cell u_cell1 (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (cell_ctrl),
    .d     (cell0_q),
    .q     (cell1_q)
  );

  assign window   = {cell1_q, cell0_q, new_col};
  assign border_b = (row_r > RW'(1)) && (col_r > CW'(1)) && window[4] && (window != 9'h1FF);

  always_comb begin
    res0.border   = border_b;
    res0.row      = bbe_pkg::ROW_W'(row_r - RW'(1));
    res0.col      = bbe_pkg::COL_W'(col_r - CW'(1));
    res0.run_last = !last_col;
    res1.border   = 1'b0;
    res1.row      = bbe_pkg::ROW_W'(row_r - RW'(1));
    res1.col      = bbe_pkg::COL_W'(wlast_r);
    res1.run_last = 1'b1;
  end

  // Two-entry result queue, head in q0.
  always_comb begin
    q0_nxt = q0_r;
    q1_nxt = q1_r;
    if (pop) begin
      q0_nxt = q1_r;
    end
    if (in_fire && n_res != 2'd0) begin
      if (cnt_pop == 2'd0) begin
        q0_nxt = res0;
        q1_nxt = res1;
      end else begin
        q1_nxt = res0;
      end
    end
    cnt_nxt = cnt_pop + (in_fire ? n_res : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      wlast_r <= CW'(RST_W - 1);
      hlast_r <= RW'(RST_H - 1);
      cnt_r   <= 2'd0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      wlast_r <= wlast_nxt;
      hlast_r <= hlast_nxt;
      cnt_r   <= cnt_nxt;
    end
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  assign out_valid    = (cnt_r != 2'd0);
  assign out_border   = q0_r.border;
  assign out_row      = q0_r.row;
  assign out_col      = q0_r.col;
  assign out_run_last = q0_r.run_last;

  `BBE_ASSERT(a_queue_depth, cnt_r <= 2'd2)
  `BBE_ASSERT_IMP(a_pair_queued, out_valid && !out_run_last, cnt_r == 2'd2)
  `BBE_ASSERT(a_col_in_frame, col_r <= wlast_r)
  `BBE_ASSERT(a_row_in_frame, row_r <= hlast_r)
  `BBE_ASSERT_NEXT(a_row_wrap, in_fire && last_col, col_r == '0)

endmodule
